FILE: rtl/core/fsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsi_pkg
// shared types and defaults of the feasible shift interval block
// ----------------------------------------------------------------------------
package fsi_pkg;

    localparam int DEF_VALUE_WIDTH = 48;
    localparam int DEF_FRAC_BITS   = 16;
    localparam int TOL_WIDTH       = 16;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_STRICT_FEASIBLE = 1'b0,
        REG_ZERO_TOLERANCE  = 1'b1
    } fsi_reg_t;

    // classification of one term, made by the front end
    typedef struct packed {
        logic first;    // loads bounds and latched flags
        logic last;     // emits a result
        logic is_int;
        logic cost;
        logic active;   // not skipped by tolerance or objective row
        logic pin;      // strict equality row, both ends to zero
        logic close_hi; // satisfied row, positive coefficient
        logic close_lo; // satisfied row, coefficient not positive
        logic div;      // violated row with nonzero coefficient
        logic dneg;     // coefficient negative, bound applies to lower end
    } fsi_flags_t;

endpackage

FILE: rtl/core/fsi_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsi_front
// classifies one term and prepares bound offsets and divider operands
// ----------------------------------------------------------------------------
module fsi_front #(
    parameter int VALUE_WIDTH = fsi_pkg::DEF_VALUE_WIDTH
) (
    input  logic                                   strict,
    input  logic [fsi_pkg::TOL_WIDTH-1:0]          tolerance,
    input  logic                                   first_term,
    input  logic                                   last_term,
    input  logic signed [VALUE_WIDTH-1:0]          var_lower,
    input  logic signed [VALUE_WIDTH-1:0]          var_upper,
    input  logic signed [VALUE_WIDTH-1:0]          var_value,
    input  logic                                   var_is_integer,
    input  logic                                   cost_positive,
    input  logic signed [VALUE_WIDTH-1:0]          coeff,
    input  logic signed [VALUE_WIDTH-1:0]          row_activity,
    input  logic signed [VALUE_WIDTH-1:0]          row_constant,
    input  logic                                   row_is_equality,
    input  logic                                   row_is_objective,
    output fsi_pkg::fsi_flags_t                    flags,
    output logic signed [VALUE_WIDTH-1:0]          low_init,
    output logic signed [VALUE_WIDTH-1:0]          high_init,
    output logic [VALUE_WIDTH-1:0]                 num_mag,
    output logic [VALUE_WIDTH-1:0]                 den_mag
);
    import fsi_pkg::*;

    localparam int W = VALUE_WIDTH;

    logic signed [W:0] low_diff;
    logic signed [W:0] high_diff;
    logic signed [W:0] num_diff;
    logic              skip;
    logic              satisfied;
    logic              coef_pos;

    // saturate a one-bit-wider difference back into the value range
    function automatic logic [W-1:0] sat_diff(input logic signed [W:0] d);
        logic [W-1:0] r;
        if (d[W] != d[W-1]) begin
            r = d[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            r = d[W-1:0];
        end
        return r;
    endfunction

    always_comb begin
        low_diff  = {var_lower[W-1], var_lower} - {var_value[W-1], var_value};
        high_diff = {var_upper[W-1], var_upper} - {var_value[W-1], var_value};
        num_diff  = {row_constant[W-1], row_constant}
                    - {row_activity[W-1], row_activity};
        low_init  = sat_diff(low_diff);
        high_init = sat_diff(high_diff);
        num_mag   = num_diff[W-1:0];
        den_mag   = coeff[W-1] ? (~coeff + 1'b1) : coeff;
        skip      = den_mag < {{(W-TOL_WIDTH){1'b0}}, tolerance};
        satisfied = row_activity >= row_constant;
        coef_pos  = !coeff[W-1] && (coeff != '0);

        flags.first    = first_term;
        flags.last     = last_term;
        flags.is_int   = var_is_integer;
        flags.cost     = cost_positive;
        flags.active   = !skip && !row_is_objective;
        flags.pin      = row_is_equality && strict;
        flags.close_hi = !row_is_equality && satisfied && coef_pos;
        flags.close_lo = !row_is_equality && satisfied && !coef_pos;
        flags.div      = !row_is_equality && !satisfied && (coeff != '0);
        flags.dneg     = coeff[W-1];
    end

endmodule

FILE: rtl/core/fsi_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsi_queue
// two-entry queue between front and back end
// ----------------------------------------------------------------------------
module fsi_queue #(
    parameter int DATA_WIDTH = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_valid,
    output logic                  wr_ready,
    input  logic [DATA_WIDTH-1:0] wr_data,
    output logic                  rd_valid,
    input  logic                  rd_pop,
    output logic [DATA_WIDTH-1:0] rd_data
);
    logic [DATA_WIDTH-1:0] mem_reg [2];
    logic                  wr_ptr_reg;
    logic                  rd_ptr_reg;
    logic [1:0]            count_reg;
    logic                  push;
    logic                  pop;

    assign wr_ready = count_reg != 2'd2;
    assign rd_valid = count_reg != 2'd0;
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

FILE: rtl/core/fsi_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsi_back
// interval state, bit-serial divider and result register
// ----------------------------------------------------------------------------
module fsi_back #(
    parameter int VALUE_WIDTH = fsi_pkg::DEF_VALUE_WIDTH,
    parameter int FRAC_BITS   = fsi_pkg::DEF_FRAC_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  fsi_pkg::fsi_flags_t           flags,
    input  logic signed [VALUE_WIDTH-1:0] low_init,
    input  logic signed [VALUE_WIDTH-1:0] high_init,
    input  logic [VALUE_WIDTH-1:0]        num_mag,
    input  logic [VALUE_WIDTH-1:0]        den_mag,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [VALUE_WIDTH-1:0] chosen_delta,
    output logic signed [VALUE_WIDTH-1:0] lower_delta,
    output logic signed [VALUE_WIDTH-1:0] upper_delta,
    output logic                          interval_empty
);
    import fsi_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int NW = W + F;
    localparam int CW = $clog2(NW + 1);

    typedef enum logic [1:0] {IDLE, DIV, FIN} state_t;

    state_t            state_reg;
    logic signed [W-1:0] lo_reg, hi_reg;
    logic              closed_reg, int_reg, cost_reg;
    logic [NW-1:0]     num_reg;
    logic [NW-1:0]     quo_reg;
    logic [W:0]        rem_reg;
    logic [W-1:0]      den_reg;
    logic [CW-1:0]     cnt_reg;
    logic              last_reg, dneg_reg;
    logic              m_valid_reg;
    logic signed [W-1:0] cand_reg, low_out_reg, high_out_reg;
    logic              empty_reg;

    logic              out_free;
    logic              res_load;
    logic signed [W-1:0] eff_lo, eff_hi, fast_lo, fast_hi;
    logic              eff_closed, act_now, need_div;
    logic [W:0]        rem_sh;
    logic              rem_ge;
    logic [NW-1:0]     qmag;
    logic              big;
    logic signed [W-1:0] dval, fin_lo, fin_hi;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        eff_lo     = flags.first ? low_init : lo_reg;
        eff_hi     = flags.first ? high_init : hi_reg;
        eff_closed = flags.first ? 1'b0 : closed_reg;
        act_now    = !eff_closed && flags.active;
        need_div   = act_now && flags.div;
        fast_lo    = eff_lo;
        fast_hi    = eff_hi;
        if (act_now) begin
            if (flags.pin) begin
                fast_lo = '0;
                fast_hi = '0;
            end else if (flags.close_hi) begin
                fast_hi = '0;
            end else if (flags.close_lo) begin
                fast_lo = '0;
            end
        end
        q_pop = (state_reg == IDLE) && q_valid && out_free;

        // a result enters the output register this cycle
        res_load = (q_pop && !need_div && flags.last)
                   || ((state_reg == FIN) && last_reg && out_free);

        rem_sh = {rem_reg[W-1:0], num_reg[NW-1]};
        rem_ge = rem_sh >= {1'b0, den_reg};

        // integer variables drop the fraction: rounding always goes toward zero here
        qmag = int_reg ? {quo_reg[NW-1:F], {F{1'b0}}} : quo_reg;
        big  = |qmag[NW-1:W-1];
        if (dneg_reg) begin
            dval = big ? {1'b1, {(W-1){1'b0}}} : (~qmag[W-1:0] + 1'b1);
        end else begin
            dval = big ? {1'b0, {(W-1){1'b1}}} : qmag[W-1:0];
        end
        fin_lo = lo_reg;
        fin_hi = hi_reg;
        if (dneg_reg) begin
            if (dval > lo_reg) fin_lo = dval;
        end else begin
            if (dval < hi_reg) fin_hi = dval;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            lo_reg      <= '0;
            hi_reg      <= '0;
            closed_reg  <= 1'b0;
            int_reg     <= 1'b0;
            cost_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= res_load || (m_valid_reg && !m_ready);
            unique case (state_reg)
                IDLE: begin
                    if (q_pop) begin
                        int_reg  <= flags.first ? flags.is_int : int_reg;
                        cost_reg <= flags.first ? flags.cost : cost_reg;
                        last_reg <= flags.last;
                        dneg_reg <= flags.dneg;
                        if (need_div) begin
                            lo_reg     <= eff_lo;
                            hi_reg     <= eff_hi;
                            closed_reg <= eff_closed;
                            num_reg    <= {num_mag, {F{1'b0}}};
                            den_reg    <= den_mag;
                            rem_reg    <= '0;
                            quo_reg    <= '0;
                            cnt_reg    <= CW'(NW);
                            state_reg  <= DIV;
                        end else begin
                            lo_reg     <= fast_lo;
                            hi_reg     <= fast_hi;
                            closed_reg <= eff_closed || (act_now && fast_lo >= fast_hi);
                            if (flags.last) begin
                                cand_reg     <= (flags.first ? flags.cost : cost_reg)
                                                ? fast_lo : fast_hi;
                                low_out_reg  <= fast_lo;
                                high_out_reg <= fast_hi;
                                empty_reg    <= fast_lo >= fast_hi;
                            end
                        end
                    end
                end
                DIV: begin
                    // one quotient bit per cycle, restoring
                    num_reg <= {num_reg[NW-2:0], 1'b0};
                    rem_reg <= rem_ge ? rem_sh - {1'b0, den_reg} : rem_sh;
                    quo_reg <= {quo_reg[NW-2:0], rem_ge};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1)) state_reg <= FIN;
                end
                FIN: begin
                    if (!last_reg || out_free) begin
                        lo_reg     <= fin_lo;
                        hi_reg     <= fin_hi;
                        closed_reg <= fin_lo >= fin_hi;
                        state_reg  <= IDLE;
                        if (last_reg) begin
                            cand_reg     <= cost_reg ? fin_lo : fin_hi;
                            low_out_reg  <= fin_lo;
                            high_out_reg <= fin_hi;
                            empty_reg    <= fin_lo >= fin_hi;
                        end
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign chosen_delta    = cand_reg;
    assign lower_delta     = low_out_reg;
    assign upper_delta     = high_out_reg;
    assign interval_empty  = empty_reg;

endmodule

FILE: rtl/core/feasible_shift_interval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feasible_shift_interval
// narrows the feasible shift interval of one variable over its term stream
// ----------------------------------------------------------------------------
// The terms of a variable stream in on the s_ side, first term marked in
// s_tuser and last term in s_tlast; one result per variable leaves on the m_
// side after the last term. A term that is skipped, or that meets an equality
// row or a satisfied inequality, is handled in the back end without the divider.
// A term of a violated inequality runs the bit-serial quotient unit, one bit
// per cycle, over VALUE_WIDTH + FRAC_BITS quotient bits. The
// front end classifies terms and a two-entry queue lets it keep taking terms
// while the back end divides. A result waiting in the output register stalls
// the back end until it is taken. Configuration is written on cfg_* and is
// always ready; write it only while no term is in flight.
// ----------------------------------------------------------------------------
module feasible_shift_interval #(
    parameter int VALUE_WIDTH = fsi_pkg::DEF_VALUE_WIDTH,
    parameter int FRAC_BITS   = fsi_pkg::DEF_FRAC_BITS,
    localparam int S_DW = ((6 * VALUE_WIDTH + 4 + 7) / 8) * 8,
    localparam int M_DW = ((3 * VALUE_WIDTH + 1 + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [0:0]                        cfg_index,
    input  logic [fsi_pkg::TOL_WIDTH-1:0]     cfg_data,
    // term stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // var_lower, var_upper, var_value, var_is_integer, cost_positive,
    // coeff, row_activity, row_constant, row_is_equality, row_is_objective
    input  logic [S_DW-1:0]                   s_tdata,
    input  logic                              s_tuser,   // first_term
    input  logic                              s_tlast,   // last_term
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // chosen shift, lower_delta, upper_delta, interval_empty
    output logic [M_DW-1:0]                   m_tdata
);
    import fsi_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int FW = $bits(fsi_flags_t);
    localparam int QW = FW + 4 * W;

    logic            strict_reg;
    logic [TOL_WIDTH-1:0] tol_reg;

    fsi_flags_t      f_flags, b_flags;
    logic [W-1:0]    f_low, f_high, f_num, f_den;
    logic [W-1:0]    b_low, b_high, b_num, b_den;
    logic [QW-1:0]   q_in, q_out;
    logic            q_valid, q_pop;
    logic [W-1:0]    cand, low_d, high_d;
    logic            empty;

    // configuration registers; the user must write them only while no term is in flight, the block does not enforce it
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strict_reg <= 1'b1;
            tol_reg    <= TOL_WIDTH'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_STRICT_FEASIBLE: strict_reg <= cfg_data[0];
                REG_ZERO_TOLERANCE:  tol_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    fsi_front #(.VALUE_WIDTH(W)) u_front (
        .strict           (strict_reg),
        .tolerance        (tol_reg),
        .first_term       (s_tuser),
        .last_term        (s_tlast),
        .var_lower        (s_tdata[W-1:0]),
        .var_upper        (s_tdata[2*W-1:W]),
        .var_value        (s_tdata[3*W-1:2*W]),
        .var_is_integer   (s_tdata[3*W]),
        .cost_positive    (s_tdata[3*W+1]),
        .coeff            (s_tdata[4*W+1:3*W+2]),
        .row_activity     (s_tdata[5*W+1:4*W+2]),
        .row_constant     (s_tdata[6*W+1:5*W+2]),
        .row_is_equality  (s_tdata[6*W+2]),
        .row_is_objective (s_tdata[6*W+3]),
        .flags            (f_flags),
        .low_init         (f_low),
        .high_init        (f_high),
        .num_mag          (f_num),
        .den_mag          (f_den)
    );

    assign q_in = {f_flags, f_low, f_high, f_num, f_den};

    // short queue decouples term intake from the divider
    fsi_queue #(.DATA_WIDTH(QW)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_tvalid),
        .wr_ready (s_tready),
        .wr_data  (q_in),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_data  (q_out)
    );

    assign {b_flags, b_low, b_high, b_num, b_den} = q_out;

    fsi_back #(.VALUE_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_pop           (q_pop),
        .flags           (b_flags),
        .low_init        (b_low),
        .high_init       (b_high),
        .num_mag         (b_num),
        .den_mag         (b_den),
        .m_valid         (m_tvalid),
        .m_ready         (m_tready),
        .chosen_delta    (cand),
        .lower_delta     (low_d),
        .upper_delta     (high_d),
        .interval_empty  (empty)
    );

    // pack result fields, zero fill up to whole bytes
    assign m_tdata = M_DW'({empty, high_d, low_d, cand});

endmodule

FILE: rtl/core/fsi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsi_checker
// port-level checks of the feasible shift interval block
// ----------------------------------------------------------------------------
module fsi_checker #(
    parameter int VALUE_WIDTH = fsi_pkg::DEF_VALUE_WIDTH,
    parameter int M_DW        = 152
) (
    input logic            aclk,
    input logic            aresetn,
    input logic            cfg_ready,
    input logic            m_tvalid,
    input logic            m_tready,
    input logic [M_DW-1:0] m_tdata
);
    localparam int W = VALUE_WIDTH;

    logic signed [W-1:0] cand, low_d, high_d;
    logic                empty;

    assign cand   = m_tdata[W-1:0];
    assign low_d  = m_tdata[2*W-1:W];
    assign high_d = m_tdata[3*W-1:2*W];
    assign empty  = m_tdata[3*W];

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // empty flag matches the ends
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (empty == (low_d >= high_d)))
        else $error("interval_empty disagrees with ends");

    // candidate is one of the ends
    a_cand: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (cand == low_d || cand == high_d))
        else $error("candidate is neither end");

    // no result right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn) cfg_ready)
        else $error("configuration port not ready");

endmodule

bind feasible_shift_interval fsi_checker #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .M_DW        (M_DW)
) u_fsi_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_ready (cfg_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);

FILE: verif/feasible_shift_interval_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feasible_shift_interval_tb
// self-checking bench for the feasible shift interval block
// ----------------------------------------------------------------------------
// Streams variables as term sequences (first term in tuser, last in tlast),
// predicts each variable's interval and candidate shift in a local model and
// checks every result transaction field by field. Directed cases cover the
// extremes and the special cases, then random variables run under several
// register settings, with random idling on both sides in all but the last one.
// ----------------------------------------------------------------------------
module feasible_shift_interval_tb;
    import fsi_pkg::*;

    localparam int VW   = 48;
    localparam int FB   = 16;
    localparam int S_DW = ((6 * VW + 4 + 7) / 8) * 8;
    localparam int M_DW = ((3 * VW + 1 + 7) / 8) * 8;
    localparam longint VMAX = (64'sd1 <<< (VW - 1)) - 1;
    localparam longint VMIN = -(64'sd1 <<< (VW - 1));
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        bit first, last, is_int, cost, is_eq, is_obj;
        longint lower, upper, value, coeff, act, cst;
    } term_t;

    typedef struct {
        longint cand, lo, hi;
        bit empty;
    } interval_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [0:0] cfg_index = '0;
    logic [TOL_WIDTH-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DW-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DW-1:0] m_tdata;

    // predictor state
    bit strict_mode;
    longint tol;
    longint low_end, high_end;
    bit closed_q, int_q, cost_q;

    interval_t expected_q[$];
    int errors = 0;
    int results_seen = 0;
    int terms_sent = 0;
    int idle_cycles = 0;
    bit idling_on = 1'b1;

    feasible_shift_interval dut (.*);

    always #5 aclk = ~aclk;

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // model arithmetic
    // ------------------------------------------------------------------------
    function automatic longint sat(bit neg, logic [127:0] mag);
        if (neg) return (mag >= (128'd1 << (VW - 1))) ? VMIN : -longint'(mag[63:0]);
        return (mag > 128'(VMAX)) ? VMAX : longint'(mag[63:0]);
    endfunction

    function automatic longint bound_shift(longint b, longint v);
        longint d;
        d = b - v; // both within 48 bits, exact in 64
        return d < 0 ? sat(1'b1, 128'(-d)) : sat(1'b0, 128'(d));
    endfunction

    // (cst - act) / coef with fixed-point scaling and rounding
    function automatic longint shift_quotient(longint act, longint cst, longint coef, bit integ);
        longint n;
        logic [127:0] num, den, q, r, whole;
        bit neg, inexact, up;
        n = cst - act;
        if (n == 0 || coef == 0) return 0;
        num = 128'(n < 0 ? -n : n) << FB;
        den = 128'(coef < 0 ? -coef : coef);
        neg = (n < 0) != (coef < 0);
        q = num / den;
        r = num % den;
        if (!integ || q >= (128'd1 << 63)) return sat(neg, q);
        inexact = (q[FB-1:0] != 0) || (r != 0);
        up = inexact && (neg ? (coef > 0) : !(coef > 0));
        whole = (q >> FB) + up;
        if (whole > (128'd1 << (VW - 1 - FB))) return sat(neg, 128'd1 << 70);
        return sat(neg, whole << FB);
    endfunction

    function automatic longint abs_coef(longint c);
        return c < 0 ? -c : c;
    endfunction

    task automatic predict_term(term_t t);
        interval_t e;
        longint d;
        if (t.first) begin
            low_end  = bound_shift(t.lower, t.value);
            high_end = bound_shift(t.upper, t.value);
            int_q = t.is_int;
            cost_q = t.cost;
            closed_q = 1'b0;
        end
        if (!closed_q && !(abs_coef(t.coeff) < tol) && !t.is_obj) begin
            if (t.is_eq) begin
                if (strict_mode) begin
                    low_end = 0;
                    high_end = 0;
                end
            end else if (t.act >= t.cst) begin
                if (t.coeff > 0) high_end = 0;
                else low_end = 0;
            end else if (t.coeff > 0) begin
                d = shift_quotient(t.act, t.cst, t.coeff, int_q);
                if (d < high_end) high_end = d;
            end else if (t.coeff < 0) begin
                d = shift_quotient(t.act, t.cst, t.coeff, int_q);
                if (d > low_end) low_end = d;
            end
            if (low_end >= high_end) closed_q = 1'b1;
        end
        if (t.last) begin
            e.cand = cost_q ? low_end : high_end;
            e.lo = low_end;
            e.hi = high_end;
            e.empty = low_end >= high_end;
            expected_q.push_back(e);
        end
    endtask

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    // an idle burst drops tvalid first, so a term is never held twice
    task automatic random_gap(input bit on);
        if (on && idling_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
    endtask

    // tvalid stays high after the accepting edge so terms can follow back to back
    task automatic send_term(term_t t);
        random_gap(1'b1);
        predict_term(t);
        s_tdata <= {{(S_DW - 6 * VW - 4){1'b0}}, t.is_obj, t.is_eq,
                    t.cst[VW-1:0], t.act[VW-1:0], t.coeff[VW-1:0], t.cost, t.is_int,
                    t.value[VW-1:0], t.upper[VW-1:0], t.lower[VW-1:0]};
        s_tuser <= t.first;
        s_tlast <= t.last;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        terms_sent++;
    endtask

    // waits for the block to drain, then lets a divide in flight finish
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (3 * (VW + FB + 2) + 10) @(posedge aclk);
    endtask

    task automatic write_reg(fsi_reg_t idx, int unsigned val);
        cfg_index <= idx;
        cfg_data <= val[TOL_WIDTH-1:0];
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == REG_STRICT_FEASIBLE) strict_mode = val[0];
        else tol = val & 16'hFFFF;
        @(posedge aclk);
    endtask

    // receiver with random backpressure bursts
    always begin
        @(posedge aclk);
        if (!aresetn || !idling_on || $urandom_range(0, 3) != 0) begin
            m_tready <= aresetn;
        end else begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
            m_tready <= 1'b1;
        end
    end

    task automatic report(string what, longint got, longint want);
        errors++;
        if (errors <= 30)
            $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
                     results_seen);
    endtask

    // result checker
    always @(posedge aclk) begin
        interval_t e;
        longint g_cand, g_lo, g_hi;
        if (aresetn && m_tvalid && m_tready) begin
            g_cand = longint'(signed'(m_tdata[VW-1:0]));
            g_lo = longint'(signed'(m_tdata[2*VW-1:VW]));
            g_hi = longint'(signed'(m_tdata[3*VW-1:2*VW]));
            if (expected_q.size() == 0) begin
                report("unexpected result", g_cand, 0);
            end else begin
                e = expected_q.pop_front();
                if (g_cand != e.cand) report("chosen shift", g_cand, e.cand);
                if (g_lo != e.lo) report("lower_delta", g_lo, e.lo);
                if (g_hi != e.hi) report("upper_delta", g_hi, e.hi);
                if (m_tdata[3*VW] != e.empty) report("interval_empty", m_tdata[3*VW], e.empty);
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    function automatic longint rand_value();
        longint v;
        case ($urandom_range(0, 5))
            0: v = VMAX;
            1: v = VMIN;
            2: v = longint'($urandom_range(0, 20)) << FB;
            3: v = -(longint'($urandom_range(0, 20)) << FB);
            4: v = longint'(signed'($urandom_range(0, 32'hFFFFFF) - 32'sh800000)) <<< 4;
            default: v = longint'({$urandom, $urandom}) >>> (64 - VW);
        endcase
        return v;
    endfunction

    function automatic term_t rand_term(bit first, bit last);
        term_t t;
        t.first = first;
        t.last = last;
        t.lower = rand_value();
        t.upper = rand_value();
        t.value = rand_value();
        t.is_int = $urandom_range(0, 1);
        t.cost = $urandom_range(0, 1);
        t.coeff = ($urandom_range(0, 7) == 0) ? longint'($urandom_range(0, 3)) : rand_value();
        t.act = rand_value();
        t.cst = rand_value();
        t.is_eq = $urandom_range(0, 7) == 0;
        t.is_obj = $urandom_range(0, 9) == 0;
        return t;
    endfunction

    function automatic term_t mk(bit f, bit l, longint lo, longint up, longint val,
                                 longint c, longint a, longint k, bit integ, bit eq);
        term_t t;
        t = rand_term(f, l);
        t.lower = lo; t.upper = up; t.value = val; t.coeff = c; t.act = a; t.cst = k;
        t.is_int = integ; t.is_eq = eq; t.is_obj = 1'b0;
        return t;
    endfunction

    task automatic test_directed();
        term_t t;
        localparam longint ONE = 64'sd1 <<< FB;
        // first and last on one item, extreme bounds saturate
        send_term(mk(1, 1, VMIN, VMAX, VMAX, ONE, 0, 5 * ONE, 0, 0));
        send_term(mk(1, 1, VMIN, VMAX, VMIN, -ONE, 0, 5 * ONE, 1, 0));
        // terms with no first term act on the current state
        send_term(mk(0, 1, 0, 0, 0, ONE, 0, ONE, 0, 0));
        // quotient rounding, real and integer, both signs
        send_term(mk(1, 0, -100 * ONE, 100 * ONE, 0, 3 * ONE, 0, 7 * ONE, 0, 0));
        send_term(mk(0, 1, 0, 0, 0, -3 * ONE, 0, 7 * ONE, 0, 0));
        send_term(mk(1, 0, -100 * ONE, 100 * ONE, 0, 3 * ONE, 0, 7 * ONE, 1, 0));
        send_term(mk(0, 1, 0, 0, 0, -3 * ONE, 0, 7 * ONE, 1, 0));
        // tiny coefficient, saturating quotient, integer overflow
        send_term(mk(1, 0, VMIN, VMAX, 0, 1, VMIN, VMAX, 0, 0));
        send_term(mk(0, 1, 0, 0, 0, -1, VMIN, VMAX, 1, 0));
        send_term(mk(1, 1, VMIN, VMAX, 0, VMIN, VMIN, VMAX, 1, 0));
        // satisfied rows close one side and the interval closes
        send_term(mk(1, 0, -ONE, ONE, 0, ONE, ONE, 0, 0, 0));
        send_term(mk(0, 0, 0, 0, 0, -ONE, ONE, 0, 0, 0));
        send_term(mk(0, 1, 0, 0, 0, ONE, 0, 9 * ONE, 0, 0));
        // equality row pins in strict mode
        send_term(mk(1, 1, -ONE, ONE, 0, ONE, 0, 0, 0, 1));
        // objective row and below-tolerance coefficient skipped
        t = mk(1, 0, -ONE, ONE, 0, ONE, ONE, 0, 0, 0);
        t.is_obj = 1'b1;
        send_term(t);
        send_term(mk(0, 1, 0, 0, 0, 0, ONE, 0, 0, 0));
        // all-ones fields to toggle every bit
        t = mk(1, 1, -1, -1, -1, -1, -1, -1, 1, 1);
        t.cost = 1'b1;
        t.is_obj = 1'b1;
        send_term(t);
        drain();
        // zero tolerance with zero coefficient, non-strict equality
        write_reg(REG_ZERO_TOLERANCE, 0);
        write_reg(REG_STRICT_FEASIBLE, 0);
        send_term(mk(1, 0, -ONE, ONE, 0, 0, 0, 5 * ONE, 0, 0));
        send_term(mk(0, 0, 0, 0, 0, 0, ONE, 0, 0, 0));
        send_term(mk(0, 1, 0, 0, 0, ONE, 0, 0, 0, 1));
        drain();
    endtask

    task automatic run_variables(int count);
        int n;
        for (int v = 0; v < count; v++) begin
            // mostly well-formed variables, occasionally stray or unterminated terms
            if ($urandom_range(0, 19) == 0) begin
                send_term(rand_term($urandom_range(0, 1), 1'b0));
            end else begin
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++) send_term(rand_term(k == 0, k == n - 1));
            end
        end
    endtask

    task automatic test_random();
        int unsigned tols[4] = '{1, 65535, 0, 300};
        for (int p = 0; p < 4; p++) begin
            write_reg(REG_ZERO_TOLERANCE, tols[p]);
            write_reg(REG_STRICT_FEASIBLE, p % 2);
            if (p == 3) idling_on = 1'b0; // no idling at the end
            run_variables(146);
            drain();
        end
    endtask

    initial begin
        strict_mode = 1'b1;
        tol = 1;
        low_end = 0; high_end = 0;
        closed_q = 0; int_q = 0; cost_q = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random();
        $display("sent %0d terms, checked %0d results", terms_sent, results_seen);
        $display("covered directed corner cases and random variables under six register setups");
        if (errors == 0 && expected_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, expected_q.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: feasible_shift_interval.f
rtl/core/fsi_pkg.sv
rtl/core/fsi_front.sv
rtl/core/fsi_queue.sv
rtl/core/fsi_back.sv
rtl/core/feasible_shift_interval.sv
rtl/core/fsi_checker.sv
verif/feasible_shift_interval_tb.sv
